### sv/kmd5_pkg.sv
// Shared types, MD5 constant tables and a helper function for the keyed MD5 ISN core.
package kmd5_pkg;

  localparam int unsigned NumSteps    = 64;
  localparam int unsigned NumWords    = 16;
  localparam int unsigned NumCfgRegs  = 8;
  localparam int unsigned CfgIdxWidth = 4;

  // Boolean function group of one MD5 step.
  typedef enum logic [1:0] {
    ROUND_F = 2'd0,
    ROUND_G = 2'd1,
    ROUND_H = 2'd2,
    ROUND_I = 2'd3
  } round_e;

  // Working state carried from one step register to the next.
  // The t word holds a + K[i] + W[g(i)] for the step that consumes it.
  typedef struct packed {
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] t;
    logic [31:0] h0;
  } stage_t;

  // Additive constants, one per step.
  localparam logic [31:0] MD5_K [NumSteps] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // Rotate amounts, indexed by {round group, step within four}.
  localparam logic [4:0] MD5_S [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  // Message word used by a given step.
  function automatic logic [3:0] msg_index(input logic [5:0] step);
    logic [8:0] prod;
    logic [3:0] idx;
    prod = '0;
    case (step[5:4])
      2'd0: prod = {3'd0, step};
      2'd1: prod = 9'({3'd0, step} * 9'd5) + 9'd1;
      2'd2: prod = 9'({3'd0, step} * 9'd3) + 9'd5;
      default: prod = 9'({3'd0, step} * 9'd7);
    endcase
    idx = prod[3:0];
    return idx;
  endfunction

endpackage

### sv/kmd5_step.sv
// One registered MD5 step: boolean function, add, rotate and chaining shift.
module kmd5_step (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  kmd5_pkg::stage_t stage_i,
  input  kmd5_pkg::round_e group_i,
  input  logic [4:0]      shift_i,
  input  logic [31:0]     kw_next_i,
  output logic            valid_o,
  output kmd5_pkg::stage_t stage_o
);
  import kmd5_pkg::*;

  logic [31:0] f_fn;
  logic [31:0] sum;
  logic [63:0] dbl;
  logic [31:0] rot;
  logic        valid_q;
  stage_t      stage_d;
  stage_t      stage_q;

  // Boolean function of the current round group.
  always_comb begin
    case (group_i)
      ROUND_F: f_fn = (stage_i.b & stage_i.c) | (~stage_i.b & stage_i.d);
      ROUND_G: f_fn = (stage_i.d & stage_i.b) | (~stage_i.d & stage_i.c);
      ROUND_H: f_fn = stage_i.b ^ stage_i.c ^ stage_i.d;
      default: f_fn = stage_i.c ^ (stage_i.b | ~stage_i.d);
    endcase
  end

  // Step arithmetic. The old d becomes the next a, so it is folded into the
  // next step's pre-added constant here.
  always_comb begin
    sum        = f_fn + stage_i.t;
    dbl        = {sum, sum} << shift_i;
    rot        = dbl[63:32];
    stage_d.b  = stage_i.b + rot;
    stage_d.c  = stage_i.b;
    stage_d.d  = stage_i.c;
    stage_d.t  = stage_i.d + kw_next_i;
    stage_d.h0 = stage_i.h0;
  end

  // Valid bit is control state; the payload needs no reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

### sv/keyed_md5_tcp_isn_generator_core.sv
// Top level of the keyed MD5 ISN core: secret registers, entry stage, 64 steps, result.
// The result strobe done_o follows an accepted request through the entry, 64 step and result registers.
// Throughput: one request per cycle; each of the 64 MD5 steps has its own register stage.
// busy_o stays low, so start_i is taken in every cycle; the receiver cannot stall.
// Reset clears all valid bits and the eight secret registers to zero at once.
module keyed_md5_tcp_isn_generator_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [31:0] source_address_i,
  input  logic [31:0] destination_address_i,
  input  logic [15:0] source_port_i,
  input  logic [15:0] destination_port_i,
  input  logic        cfg_we_i,
  input  logic [kmd5_pkg::CfgIdxWidth-1:0] cfg_index_i,
  input  logic [63:0] cfg_wdata_i,
  output logic        done_o,
  output logic [31:0] sequence_number_o
);
  import kmd5_pkg::*;

  logic [63:0] secret_q [NumCfgRegs];
  logic [31:0] sw [NumWords];
  logic [31:0] kw [NumSteps];
  logic        accept;
  logic [NumSteps:0] vld;
  stage_t      stage [NumSteps+1];
  stage_t      entry_d;
  stage_t      entry_q;
  logic        entry_vld_q;
  logic        done_q;
  logic [31:0] seq_q;

  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  // Secret registers; writes beyond the last register are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumCfgRegs; i++) begin
        secret_q[i] <= '0;
      end
    end else if (cfg_we_i && !cfg_index_i[CfgIdxWidth-1]) begin
      secret_q[cfg_index_i[CfgIdxWidth-2:0]] <= cfg_wdata_i;
    end
  end

  // Split the registers into message words and pre-add each step's constant.
  for (genvar w = 0; w < NumWords; w++) begin : g_words
    assign sw[w] = secret_q[w/2][32*(w%2) +: 32];
  end

  for (genvar k = 0; k < NumSteps; k++) begin : g_kw
    assign kw[k] = MD5_K[k] + sw[msg_index(6'(k))];
  end

  // Entry stage: build the chaining value from the four-tuple and the last message word.
  always_comb begin
    entry_d.b  = destination_address_i;
    entry_d.c  = {source_port_i, destination_port_i};
    entry_d.d  = sw[NumWords-1];
    entry_d.t  = source_address_i + kw[0];
    entry_d.h0 = source_address_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_vld_q <= 1'b0;
    end else begin
      entry_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      entry_q <= entry_d;
    end
  end

  assign vld[0]   = entry_vld_q;
  assign stage[0] = entry_q;

  // Step pipeline. The last step pre-adds nothing, so its t output is the final a.
  for (genvar k = 0; k < NumSteps; k++) begin : g_step
    logic [31:0] kw_next;
    if (k < NumSteps - 1) begin : g_mid
      assign kw_next = kw[k+1];
    end else begin : g_last
      assign kw_next = '0;
    end

    kmd5_step u_step (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .valid_i   (vld[k]),
      .stage_i   (stage[k]),
      .group_i   (round_e'(2'(k / 16))),
      .shift_i   (MD5_S[4*(k/16) + (k%4)]),
      .kw_next_i (kw_next),
      .valid_o   (vld[k+1]),
      .stage_o   (stage[k+1])
    );
  end

  // Feed-forward addition of the first word and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld[NumSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld[NumSteps]) begin
      seq_q <= stage[NumSteps].h0 + stage[NumSteps].t;
    end
  end

  assign done_o            = done_q;
  assign sequence_number_o = seq_q;

  // A result strobe is only raised for a request that was accepted and passed the entry, step and result registers.
  a_done_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, 66))
    else $error("result strobe without a matching request");

  // An accepted request always enters the entry stage.
  a_entry : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> vld[0])
    else $error("accepted request lost at entry");

  // The last step always hands its item to the result register.
  a_exit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld[NumSteps] |=> done_o)
    else $error("item lost after the last step");

endmodule
